/* design/vdft_pkg.sv */
// Package for the vertex dedup / fan triangulation core.
// Holds store geometry, hash constant, store entry and sequencer state types.
// No dependencies.
`timescale 1ns / 1ps

package vdft_pkg;

    // Dedup store geometry (depth must be a power of two)
    localparam int TABLE_DEPTH = 4096;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int PCNT_W      = SLOT_W + 1;

    localparam int IDX_W = 16;
    localparam int KEY_W = 3 * IDX_W;
    localparam int NV_W  = IDX_W + 1;

    localparam logic [31:0]   HASH_MUL    = 32'd2654435761;
    localparam logic [NV_W-1:0] INDEX_SPACE = NV_W'(1) << IDX_W;

    // One dedup store entry
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] vertex;
    } ent_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HOME,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

/* design/vdft_if.sv */
// Valid/ready channel interfaces for corner inputs and vertex/triangle results.
// Depends on nothing.
`timescale 1ns / 1ps

interface vdft_corner_if;
    logic        valid;
    logic        ready;
    logic        first_corner;
    logic [15:0] pos_index;
    logic [15:0] tex_index;
    logic [15:0] norm_index;

    modport source (output valid, first_corner, pos_index, tex_index, norm_index,
                    input ready);
    modport sink   (input valid, first_corner, pos_index, tex_index, norm_index,
                    output ready);
endinterface

interface vdft_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] vertex_index;
    logic        new_vertex;
    logic        triangle_valid;
    logic [15:0] tri_first;
    logic [15:0] tri_prev;
    logic        table_full;

    modport source (output valid, vertex_index, new_vertex, triangle_valid, tri_first,
                    tri_prev, table_full, input ready);
    modport sink   (input valid, vertex_index, new_vertex, triangle_valid, tri_first,
                    tri_prev, table_full, output ready);
endinterface

/* design/vdft_hash.sv */
// Shared hash multiplier: registered low 32 bits of operand * golden constant.
// Depends on vdft_pkg.
`timescale 1ns / 1ps

module vdft_hash
    import vdft_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [31:0] opnd,
    output logic [31:0] hash
);

    logic [31:0] prod;
    logic [31:0] hash_reg;

    // One 32x32 multiply, low word kept
    assign prod = opnd * HASH_MUL;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hash_reg <= prod;
        end
    end

    assign hash = hash_reg;

endmodule

/* design/vdft_store.sv */
// Dedup store memory: one write port, one registered read port.
// Depends on vdft_pkg.
`timescale 1ns / 1ps

module vdft_store
    import vdft_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [SLOT_W-1:0] waddr,
    input  ent_t              wdata,
    input  logic [SLOT_W-1:0] raddr,
    output ent_t              rdata
);

    ent_t mem [TABLE_DEPTH];
    ent_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/vertex_dedup_fan_triangulator_core.sv */
// Top level: sequencer for hashing, linear probing, insertion and fan triangles.
// Depends on vdft_pkg, vdft_if, vdft_hash, vdft_store.
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------------------
//   corner   | in  | first_corner, pos_index, tex_index, norm_index
//   result   | out | vertex_index, new_vertex, triangle_valid, tri_first,
//            |     | tri_prev, table_full
//
// A corner passes ST_IDLE, ST_HASH1, ST_HASH2 and ST_HOME, then ST_READ and ST_CMP
// for each probe of the store (one read port, read then compare), then ST_DONE;
// a full miss probes all TABLE_DEPTH slots. After reset the store is swept once,
// one slot a cycle, with corner.ready low. A finished result sits in an output
// register, so the next corner is taken while it waits; the core stalls only at
// its final step if the previous result is still not taken.
`timescale 1ns / 1ps

module vertex_dedup_fan_triangulator_core
    import vdft_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    vdft_corner_if.sink     corner,
    vdft_result_if.source   result
);

    state_t state_reg, state_next;

    // Captured corner
    logic             first_reg;
    logic [KEY_W-1:0] key_reg;

    // Probe state
    logic [SLOT_W-1:0] slot_reg;
    logic [PCNT_W-1:0] probe_cnt_reg;
    logic [PCNT_W-1:0] clr_cnt_reg;

    // Lookup outcome
    logic [IDX_W-1:0] res_idx_reg;
    logic             res_new_reg;
    logic             res_full_reg;

    // Vertex allocation and fan state
    logic [NV_W-1:0]  next_vertex_reg;
    logic [IDX_W-1:0] fan_first_reg;
    logic [IDX_W-1:0] fan_prev_reg;
    logic [1:0]       corner_count_reg;

    // Output register
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_new_reg;
    logic             out_tri_reg;
    logic [IDX_W-1:0] out_tf_reg;
    logic [IDX_W-1:0] out_tp_reg;
    logic             out_full_reg;

    // Control
    logic        in_take;
    logic        hash_load;
    logic [31:0] hash_opnd;
    logic [31:0] hash;
    logic        out_free;
    logic        hit;
    logic        empty;
    logic        last_probe;
    logic [1:0]  face_cc;
    logic        tri_emit;

    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    ent_t              mem_wdata;
    ent_t              mem_rdata;

    vdft_hash u_hash (
        .clk  (clk),
        .load (hash_load),
        .opnd (hash_opnd),
        .hash (hash)
    );

    vdft_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (slot_reg),
        .rdata (mem_rdata)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign empty      = !mem_rdata.valid;
    assign hit        = mem_rdata.valid && (mem_rdata.key == key_reg);
    assign last_probe = (probe_cnt_reg == PCNT_W'(TABLE_DEPTH - 1));

    // Corner count of the face, restarted by a first corner
    assign face_cc  = first_reg ? 2'd0 : corner_count_reg;
    assign tri_emit = !res_full_reg && (face_cc == 2'd2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == PCNT_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (corner.valid)
                begin
                    state_next = ST_HASH1;
                end
            end
            ST_HASH1: state_next = ST_HASH2;
            ST_HASH2: state_next = ST_HOME;
            ST_HOME:  state_next = ST_READ;
            ST_READ:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (hit || empty || last_probe)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_take   = 1'b0;
        hash_load = 1'b0;
        hash_opnd = 32'b0;
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[SLOT_W-1:0];
            end
            ST_IDLE:
            begin
                in_take = corner.valid;
            end
            ST_HASH1:
            begin
                hash_load = 1'b1;
                hash_opnd = {16'b0, key_reg[KEY_W-1 -: IDX_W]};
            end
            ST_HASH2:
            begin
                hash_load = 1'b1;
                hash_opnd = hash ^ {16'b0, key_reg[2*IDX_W-1 -: IDX_W]};
            end
            ST_CMP:
            begin
                // Insert into the empty slot when index space remains
                if (empty && (next_vertex_reg < INDEX_SPACE))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{valid: 1'b1, key: key_reg,
                                  vertex: next_vertex_reg[IDX_W-1:0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign corner.ready = (state_reg == ST_IDLE);

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            next_vertex_reg  <= '0;
            fan_first_reg    <= '0;
            fan_prev_reg     <= '0;
            corner_count_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_tri_reg      <= 1'b0;
            out_tf_reg       <= '0;
            out_tp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + PCNT_W'(1);
            end

            if (state_reg == ST_CMP && empty && (next_vertex_reg < INDEX_SPACE))
            begin
                next_vertex_reg <= next_vertex_reg + NV_W'(1);
            end

            // Output valid: load beats drain
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Fan update and result load
            if (state_reg == ST_DONE && out_free)
            begin
                out_tri_reg <= tri_emit;
                out_tf_reg  <= tri_emit ? fan_first_reg : '0;
                out_tp_reg  <= tri_emit ? fan_prev_reg : '0;
                if (!res_full_reg)
                begin
                    if (face_cc == 2'd0)
                    begin
                        fan_first_reg <= res_idx_reg;
                    end
                    fan_prev_reg     <= res_idx_reg;
                    corner_count_reg <= (face_cc == 2'd2) ? face_cc : face_cc + 2'd1;
                end
                else
                begin
                    corner_count_reg <= face_cc;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            first_reg <= corner.first_corner;
            key_reg   <= {corner.pos_index, corner.tex_index, corner.norm_index};
        end

        if (state_reg == ST_HOME)
        begin
            slot_reg      <= hash[SLOT_W-1:0] ^ key_reg[SLOT_W-1:0];
            probe_cnt_reg <= '0;
        end
        else if (state_reg == ST_CMP && !hit && !empty)
        begin
            slot_reg      <= slot_reg + SLOT_W'(1);
            probe_cnt_reg <= probe_cnt_reg + PCNT_W'(1);
        end

        // Lookup outcome
        if (state_reg == ST_CMP)
        begin
            if (hit)
            begin
                res_idx_reg  <= mem_rdata.vertex;
                res_new_reg  <= 1'b0;
                res_full_reg <= 1'b0;
            end
            else if (empty && (next_vertex_reg < INDEX_SPACE))
            begin
                res_idx_reg  <= next_vertex_reg[IDX_W-1:0];
                res_new_reg  <= 1'b1;
                res_full_reg <= 1'b0;
            end
            else
            begin
                res_idx_reg  <= '0;
                res_new_reg  <= 1'b0;
                res_full_reg <= 1'b1;
            end
        end

        if (state_reg == ST_DONE && out_free)
        begin
            out_idx_reg  <= res_idx_reg;
            out_new_reg  <= res_new_reg;
            out_full_reg <= res_full_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.vertex_index   = out_idx_reg;
    assign result.new_vertex     = out_new_reg;
    assign result.triangle_valid = out_tri_reg;
    assign result.tri_first      = out_tf_reg;
    assign result.tri_prev       = out_tp_reg;
    assign result.table_full     = out_full_reg;

endmodule
